### hdl/bmhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared constants and types for the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int KEY_W        = 32;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 1024;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [STATUS_W-1:0]     status;
  } res_t;

endpackage

### hdl/binary_min_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue of signed keys: push sifts up, pop returns the
// smallest key and sifts the last element down from the root.
//
//   channel  direction  handshake           payload
//   in_      in         in_valid/in_stall   in_opcode, in_key_in
//   out_     out        out_valid/out_stall out_key_out, out_status,
//                                           out_fill_count
//
// push: each level the key climbs reads the parent and moves it down if above the key
// pop: each level of descent reads up to two children and lifts the smaller if below the key
// empty pop / full push: no memory access; a push level takes one memory read,
// a pop level up to two; in_stall is high while an item is in flight
// one result may wait in the output register; a second waits in the sequencer
// synchronous active-low reset empties the heap; memory contents are not cleared
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_opcode,
  input  logic signed [bmhq_pkg::KEY_W-1:0]    in_key_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bmhq_pkg::KEY_W-1:0]    out_key_out,
  output logic [bmhq_pkg::STATUS_W-1:0]        out_status,
  output logic [CW-1:0]                        out_fill_count
);

  logic                              wr_en, rd_en;
  logic [AW-1:0]                     wr_addr, rd_addr;
  logic signed [bmhq_pkg::KEY_W-1:0] wr_data, rd_data;
  logic                              done, out_free;
  bmhq_pkg::res_t                    res;
  logic [CW-1:0]                     res_count;

  logic                              out_valid_r;
  bmhq_pkg::res_t                    out_res_r;
  logic [CW-1:0]                     out_count_r;

  assign out_free = !out_valid_r || !out_stall;

  bmhq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_key    (in_key_in),
    .in_stall  (in_stall),
    .out_free  (out_free),
    .done      (done),
    .res       (res),
    .res_count (res_count),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  bmhq_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res_r   <= res;
      out_count_r <= res_count;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_out    = out_res_r.key;
  assign out_status     = out_res_r.status;
  assign out_fill_count = out_count_r;

endmodule

### hdl/bmhq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_store
// Heap key memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmhq_store #(
  parameter int DEPTH = bmhq_pkg::DEF_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [bmhq_pkg::KEY_W-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr,
  output logic signed [bmhq_pkg::KEY_W-1:0] rd_data
);

  logic signed [bmhq_pkg::KEY_W-1:0] mem [DEPTH];
  logic signed [bmhq_pkg::KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/bmhq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sift sequencer: element count, push sift-up and pop sift-down over the
// key memory, one read and one write a cycle.
// ----------------------------------------------------------------------------
module bmhq_ctrl #(
  parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_opcode,
  input  logic signed [bmhq_pkg::KEY_W-1:0] in_key,
  output logic                              in_stall,
  input  logic                              out_free,
  output logic                              done,
  output bmhq_pkg::res_t                    res,
  output logic [CW-1:0]                     res_count,
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic signed [bmhq_pkg::KEY_W-1:0] wr_data,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr,
  input  logic signed [bmhq_pkg::KEY_W-1:0] rd_data
);

  localparam int XW = AW + 2;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_CHK   = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_POP_TOP  = 4'd3;
  localparam logic [3:0] S_POP_LAST = 4'd4;
  localparam logic [3:0] S_DN_CHK   = 4'd5;
  localparam logic [3:0] S_DN_RDA   = 4'd6;
  localparam logic [3:0] S_DN_RDB   = 4'd7;
  localparam logic [3:0] S_DN_CMP   = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]                        state_r, state_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [AW-1:0]                     idx_r, idx_nxt;
  logic [AW-1:0]                     bidx_r, bidx_nxt;
  logic signed [bmhq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic signed [bmhq_pkg::KEY_W-1:0] best_r, best_nxt;
  bmhq_pkg::res_t                    res_r, res_nxt;

  logic [AW-1:0] parent;
  logic [XW-1:0] left_x, right_x, count_x;
  logic          accept;

  assign parent  = (idx_r - AW'(1)) >> 1;
  assign left_x  = {1'b0, idx_r, 1'b1};
  assign right_x = left_x + XW'(1);
  assign count_x = XW'(count_r);
  assign accept  = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    bidx_nxt  = bidx_r;
    key_nxt   = key_r;
    best_nxt  = best_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = key_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    done      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt.key    = '0;
          res_nxt.status = bmhq_pkg::ST_OK;
          key_nxt        = in_key;
          if (in_opcode == bmhq_pkg::OP_POP) begin
            if (count_r == '0) begin
              res_nxt.status = bmhq_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              count_nxt = count_r - CW'(1);
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_POP_TOP;
            end
          end else begin
            if (count_r == CW'(CAPACITY)) begin
              res_nxt.status = bmhq_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              count_nxt = count_r + CW'(1);
              idx_nxt   = count_r[AW-1:0];
              state_nxt = S_UP_CHK;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_data <= key_r) begin
          state_nxt = S_DONE;
        end else begin
          wr_data   = rd_data;
          idx_nxt   = parent;
          state_nxt = S_UP_CHK;
        end
      end
      S_POP_TOP: begin
        res_nxt.key = rd_data;
        rd_en       = 1'b1;
        rd_addr     = count_r[AW-1:0];
        idx_nxt     = '0;
        state_nxt   = S_POP_LAST;
      end
      S_POP_LAST: begin
        key_nxt   = rd_data;
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (left_x >= count_x) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = left_x[AW-1:0];
          state_nxt = S_DN_RDA;
        end
      end
      S_DN_RDA: begin
        best_nxt = rd_data;
        bidx_nxt = left_x[AW-1:0];
        if (right_x < count_x) begin
          rd_en     = 1'b1;
          rd_addr   = right_x[AW-1:0];
          state_nxt = S_DN_RDB;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_RDB: begin
        if (rd_data < best_r) begin
          best_nxt = rd_data;
          bidx_nxt = right_x[AW-1:0];
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (best_r >= key_r) begin
          state_nxt = S_DONE;
        end else begin
          wr_data   = best_r;
          idx_nxt   = bidx_r;
          state_nxt = S_DN_CHK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    bidx_r <= bidx_nxt;
    key_r  <= key_nxt;
    best_r <= best_nxt;
    res_r  <= res_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res       = res_r;
  assign res_count = count_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ({1'b0, wr_addr} < (AW+1)'(CAPACITY)))
    else $error("memory write beyond capacity");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!wr_en && !done))
    else $error("memory write or result while idle");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (done && res_r.status == bmhq_pkg::ST_FULL) |-> (count_r == CW'(CAPACITY)))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (done && res_r.status == bmhq_pkg::ST_EMPTY) |-> (count_r == '0 && res_r.key == '0))
    else $error("empty status on a non-empty heap");

endmodule
